/* src/dif_pkg.sv */
// Shared types and constants for the 1D explicit diffusion block.
// No dependencies.
package dif_pkg;
   localparam int CELL_COUNT_DEFAULT = 64;
   localparam int LEVEL_W = 18;
   localparam int COUNT_W = 21;
   localparam logic [31:0] INV_DX_RESET = 32'd65536;

   localparam logic [0:0] CSR_BOUNDARY = 1'b0;
   localparam logic [0:0] CSR_INV_DX   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_GAIN, ST_GAIN_SAT, ST_DIV, ST_POP_ADD,
      ST_RD, ST_LAP, ST_MUL, ST_WR, ST_CNT, ST_CNT2, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;      // capture request beat
      logic gain;      // dt * inv_dx multiply
      logic gain_sat;
      logic div_step;  // one quotient bit
      logic pop_add;
      logic rd;        // read cell at index
      logic lap;
      logic mul;
      logic wr;        // write updated cell, advance index unless last
      logic cnt;
      logic cnt2;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic div_done;
      logic last_cell;
   } sts_type;
endpackage

/* src/diffusion_1d_explicit_step.sv */
// Top level of the 1D explicit diffusion block: controller plus datapath.
// Depends on dif_pkg, dif_ctrl, dif_datapath.
//
// Usage: request beats on req_* carry one item; each gives one rsp_* beat.
// Config writes on csr_* (index 0 boundary_level, 1 inv_dx_squared) are
// taken any time, and must land only while the block is idle.
// From request beat to rsp_tvalid, a population item runs 24 divider
// steps, the pop add and the count stages; a diffusion item runs the gain
// multiply and saturate, then one read/update/write pass per cell through
// a single multiplier, then the count stages.
// One item at a time; req_tready drops until the result beat is taken.
// A stalled receiver holds rsp_tvalid and payload until rsp_tready.
// Reset (synchronous) zeroes all cells via per-cell valid bits and restores
// register reset values; no clearing pass.
module diffusion_1d_explicit_step #(
   parameter int CELL_COUNT = dif_pkg::CELL_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // pop_change[7:0], cavity_volume[28:8], time_step[60:29]
   input  logic        req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // first_cell_level[17:0], solvent_count[38:18], out_of_range[39]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   import dif_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic signed [17:0] lvl;
   logic [20:0] cnt;
   logic oor;

   assign csr_ready = 1'b1;

   dif_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .cmd
   );

   dif_datapath #(.CELL_COUNT(CELL_COUNT)) u_dp (
      .clock, .reset, .cmd, .sts,
      .csr_valid(csr_valid && csr_ready), .csr_index, .csr_data,
      .in_mode(req_tuser), .in_pop(req_tdata[7:0]), .in_vol(req_tdata[28:8]),
      .in_dt(req_tdata[60:29]),
      .lvl_out(lvl), .cnt_out(cnt), .oor_out(oor)
   );

   assign rsp_tdata = {oor, cnt, lvl};

   logic unused;
   assign unused = ^req_tdata[63:61];
endmodule

/* src/dif_datapath.sv */
// Datapath of the diffusion block: cell memory, gain multiplier, restoring divider,
// per-cell update pipe and solvent count. Depends on dif_pkg.
module dif_datapath #(
   parameter int CELL_COUNT = dif_pkg::CELL_COUNT_DEFAULT,
   localparam int IDX_W = $clog2(CELL_COUNT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dif_pkg::cmd_type      cmd,
   output dif_pkg::sts_type      sts,
   input  logic                  csr_valid,
   input  logic [0:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  logic                  in_mode,
   input  logic signed [7:0]     in_pop,
   input  logic [20:0]           in_vol,
   input  logic [31:0]           in_dt,
   output logic signed [17:0]    lvl_out,
   output logic [20:0]           cnt_out,
   output logic                  oor_out
);
   import dif_pkg::*;

   logic [16:0] bnd_ff;
   logic [31:0] inv_ff;
   logic        mode_ff;
   logic signed [7:0] pop_ff;
   logic [20:0] vol_ff;
   logic [31:0] dt_ff;
   logic [63:0] gprod_ff;
   logic [31:0] fac_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [5:0]  dcnt_ff;
   logic [20:0] rem_ff;
   logic [23:0] quo_ff;
   logic signed [17:0] mem [CELL_COUNT];
   logic signed [17:0] left_ff, cur_ff, nxt_ff, c0_ff;
   logic signed [17:0] rdata_ff;
   logic signed [20:0] lap_ff;
   logic signed [53:0] prod_ff;
   logic [38:0] cprod_ff;

   // valid tracking for the whole row: reset clears a valid bit per cell, and
   // a cell whose bit is clear reads as zero
   logic [CELL_COUNT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_ff <= '0;
         inv_ff <= INV_DX_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_BOUNDARY) bnd_ff <= csr_data[16:0];
         else inv_ff <= csr_data;
      end
   end

   logic [20:0] vol_eff;
   assign vol_eff = (in_vol == '0) ? 21'd1 : in_vol;

   // read port: rdata for cell idx+1 (or boundary)
   logic [IDX_W-1:0] ridx;
   logic             at_last;
   assign at_last = (idx_ff == IDX_W'(CELL_COUNT - 1));
   assign ridx    = at_last ? idx_ff : idx_ff + 1'b1;

   logic signed [17:0] rd_val;
   always_ff @(posedge clock) begin
      rdata_ff <= mem[ridx];
   end
   logic rvld_ff, rlast_ff;
   always_ff @(posedge clock) begin
      rvld_ff  <= vld_ff[ridx];
      rlast_ff <= at_last;
   end
   assign rd_val = rlast_ff ? $signed({1'b0, bnd_ff}) : (rvld_ff ? rdata_ff : 18'sd0);

   // divider step: restoring, 24 quotient bits of (|pop|<<16)/vol
   logic [21:0] trial;
   assign trial = {rem_ff, quo_ff[23]} - {1'b0, vol_ff};

   // quotient reaches 2^23, so the sum is wide and saturated afterwards
   logic signed [24:0] inc;
   logic signed [25:0] pop_sum;
   logic signed [17:0] pop_sat;
   assign inc     = pop_ff[7] ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign pop_sum = 26'(c0_ff) + 26'(inc);
   assign pop_sat = (pop_sum > 26'sd131071) ? 18'sd131071 :
                    (pop_sum < -26'sd131072) ? -18'sd131072 : pop_sum[17:0];

   logic signed [54:0] upd;
   assign upd = 55'(cur_ff) + 55'(prod_ff >>> 16);

   function automatic logic signed [17:0] sat18(input logic signed [54:0] v);
      if (v > 55'sd131071) return 18'sd131071;
      if (v < -55'sd131072) return -18'sd131072;
      return v[17:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         idx_ff  <= '0;
         dcnt_ff <= '0;
         c0_ff   <= '0;
      end else begin
         if (cmd.load) begin
            mode_ff <= in_mode;
            pop_ff  <= in_pop;
            vol_ff  <= vol_eff;
            dt_ff   <= in_dt;
            idx_ff  <= '0;
            dcnt_ff <= '0;
            rem_ff  <= '0;
            // dividend |pop| << 16 shifts out of the top as quotient bits enter
            quo_ff  <= {in_pop[7] ? 8'(-in_pop) : 8'(in_pop), 16'd0};
         end
         if (cmd.gain) gprod_ff <= 64'(dt_ff) * 64'(inv_ff);
         if (cmd.gain_sat)
            fac_ff <= (gprod_ff[63:48] != '0) ? 32'hFFFF_FFFF : gprod_ff[47:16];
         if (cmd.div_step) begin
            dcnt_ff <= dcnt_ff + 1'b1;
            if (!trial[21]) begin
               rem_ff <= trial[20:0];
               quo_ff <= {quo_ff[22:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[19:0], quo_ff[23]};
               quo_ff <= {quo_ff[22:0], 1'b0};
            end
         end
         if (cmd.pop_add) begin
            c0_ff     <= pop_sat;
            mem[0]    <= pop_sat;
            vld_ff[0] <= 1'b1;
         end
         if (cmd.rd && idx_ff == '0) begin
            cur_ff  <= c0_ff;
            left_ff <= c0_ff;
         end
         if (cmd.lap) begin
            nxt_ff <= rd_val;
            lap_ff <= 21'(rd_val) - 21'(cur_ff) - 21'(cur_ff) + 21'(left_ff);
         end
         if (cmd.mul) prod_ff <= $signed({1'b0, fac_ff}) * lap_ff;
         if (cmd.wr) begin
            mem[idx_ff]    <= sat18(upd);
            vld_ff[idx_ff] <= 1'b1;
            if (idx_ff == '0) c0_ff <= sat18(upd);
            left_ff <= cur_ff;
            cur_ff  <= nxt_ff;
            if (!at_last) idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.cnt) cprod_ff <= 39'(c0_ff[16:0]) * 39'(vol_ff);
         if (cmd.cnt2) begin
            lvl_out <= c0_ff;
            oor_out <= c0_ff[17] || (c0_ff > 18'sd65536);
            if (c0_ff <= 18'sd0) cnt_out <= '0;
            else if (cprod_ff[38:37] != '0) cnt_out <= 21'h1F_FFFF;
            else cnt_out <= cprod_ff[36:16];
         end
      end
   end

   // the dividend 8 bits of |pop| plus 16 zero bits: 24 steps total
   assign sts.mode      = mode_ff;
   assign sts.div_done  = (dcnt_ff == 6'd24);
   assign sts.last_cell = at_last;
endmodule

/* src/dif_ctrl.sv */
// Sequencer of the diffusion block: walks divider, gain and per-cell passes.
// Depends on dif_pkg.
module dif_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  dif_pkg::sts_type sts,
   output dif_pkg::cmd_type cmd
);
   import dif_pkg::*;

   state_type state_ff, state_in;
   logic      rv_ff, rv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rv_in    = rv_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready) begin
            cmd.load = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: if (sts.mode) begin
            cmd.gain = 1'b1; state_in = ST_GAIN_SAT;
         end else state_in = ST_DIV;
         ST_GAIN_SAT: begin cmd.gain_sat = 1'b1; state_in = ST_RD; end
         ST_DIV: if (sts.div_done) state_in = ST_POP_ADD;
                 else cmd.div_step = 1'b1;
         ST_POP_ADD: begin cmd.pop_add = 1'b1; state_in = ST_CNT; end
         ST_RD:  begin cmd.rd = 1'b1; state_in = ST_LAP; end
         ST_LAP: begin cmd.lap = 1'b1; state_in = ST_MUL; end
         ST_MUL: begin cmd.mul = 1'b1; state_in = ST_WR; end
         ST_WR: begin
            cmd.wr   = 1'b1;
            state_in = sts.last_cell ? ST_CNT : ST_RD;
         end
         ST_CNT:  begin cmd.cnt = 1'b1; state_in = ST_CNT2; end
         ST_CNT2: begin cmd.cnt2 = 1'b1; state_in = ST_OUT; end
         ST_OUT:  begin rv_in = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("multiple datapath commands");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !rv_ff) else $error("load with pending result");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> rsp_tvalid) else $error("result not raised");
endmodule
